FILE: hdl/mric_pkg.sv
// ============================================================================
// mric_pkg
// Shared constants and types for the mixed-radix index converter.
// ============================================================================
`default_nettype none

package mric_pkg;

    // Width of a flat row-major index
    localparam int FLAT_BITS = 31;

    // Quotient bits resolved per pipeline stage in the dividers
    localparam int DIV_STEPS_PER_STAGE = 2;

    // Configuration register indexes
    localparam int REG_NUM_DIMS    = 0;
    localparam int REG_EXTENT_BASE = 1;

    localparam int              NUM_DIMS_BITS  = 3;
    localparam logic [2:0]      NUM_DIMS_RESET = 3'd4;

    typedef enum logic
    {
        FUNC_SPLIT = 1'b0,
        FUNC_FOLD  = 1'b1
    } func_t;

endpackage

`default_nettype wire

FILE: hdl/mric_if.sv
// ============================================================================
// mric_if
// Request and response channels of the index converter (valid/ready).
// ============================================================================
`default_nettype none

interface mric_req_if #(
    parameter int MAX_DIMS   = 4,
    parameter int COORD_BITS = 16
);
    import mric_pkg::*;

    logic                           valid;
    logic                           ready;
    func_t                          func;
    logic [FLAT_BITS-1:0]           flat_in;
    logic [MAX_DIMS*COORD_BITS-1:0] coord_in;

    modport source (output valid, func, flat_in, coord_in, input ready);
    modport sink   (input valid, func, flat_in, coord_in, output ready);
endinterface

interface mric_rsp_if #(
    parameter int MAX_DIMS   = 4,
    parameter int COORD_BITS = 16
);
    import mric_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [FLAT_BITS-1:0]           flat_out;
    logic [MAX_DIMS*COORD_BITS-1:0] coord_out;
    logic                           out_of_range;

    modport source (output valid, flat_out, coord_out, out_of_range, input ready);
    modport sink   (input valid, flat_out, coord_out, out_of_range, output ready);
endinterface

`default_nettype wire

FILE: hdl/mixed_radix_index_convert.sv
// ============================================================================
// mixed_radix_index_convert
// Row-major flat index <-> per-dimension coordinates, extents from registers.
// ----------------------------------------------------------------------------
// req carries one word per conversion: func 0 splits flat_in into coordinates,
// func 1 folds coord_in (dimension i at bits [i*COORD_BITS +: COORD_BITS])
// into a flat index. rsp returns flat_out, coord_out and out_of_range.
// Extents and num_dims are written through cfg_we/cfg_index/cfg_data; write
// them only while no word is in flight.
// Throughput: one word per cycle while rsp is not stalled. Each dimension owns
// a 16-stage restoring divider resolving two quotient bits a stage, and the
// fold multiplies and accumulates in the first two stages of the same section.
// Reset empties the pipeline, sets num_dims to 4 and every extent to 1.
// When rsp stalls the whole pipeline holds and req.ready drops; nothing is
// lost or repeated.
// ============================================================================
`default_nettype none

module mixed_radix_index_convert #(
    parameter int MAX_DIMS   = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [$clog2(MAX_DIMS+1)-1:0]  cfg_index,
    input  wire logic [COORD_BITS-1:0]          cfg_data,
    mric_req_if.sink                            req,
    mric_rsp_if.source                          rsp
);
    import mric_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIMS+1);
    localparam int BPS   = DIV_STEPS_PER_STAGE;
    localparam int SPD   = (FLAT_BITS + BPS - 1) / BPS;
    localparam int NST   = MAX_DIMS*SPD + 2;
    localparam int PW    = COORD_BITS + FLAT_BITS;

    typedef struct packed {
        func_t                                func;
        logic [FLAT_BITS-1:0]                 n;
        logic [COORD_BITS-1:0]                rem;
        logic [MAX_DIMS-1:0][COORD_BITS-1:0]  coord;
        logic                                 bad;
        logic                                 cnz;
        logic [FLAT_BITS-1:0]                 sum;
        logic [FLAT_BITS-1:0]                 stride;
        logic                                 big;
        logic [PW-1:0]                        tprod;
        logic [PW-1:0]                        sprod;
    } stage_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NUM_DIMS_BITS-1:0]             num_dims_reg;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0]  extent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= NUM_DIMS_RESET;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                extent_reg[i] <= COORD_BITS'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == IDX_W'(REG_NUM_DIMS))
            begin
                num_dims_reg <= cfg_data[NUM_DIMS_BITS-1:0];
            end
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                if (cfg_index == IDX_W'(REG_EXTENT_BASE + i))
                begin
                    extent_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Per-dimension divisor and stride factor; unused dimensions act as 1
    logic [MAX_DIMS-1:0]                  used;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0]  div_ext;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0]  fold_ext;
    logic                                 zero_ext;

    always_comb
    begin
        zero_ext = 1'b0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            used[i] = (i == 0) || ({1'b0, num_dims_reg} > 4'(i));
            div_ext[i] = (used[i] && extent_reg[i] != '0) ? extent_reg[i]
                                                            : COORD_BITS'(1);
            fold_ext[i] = used[i] ? extent_reg[i] : COORD_BITS'(1);
            if (used[i] && extent_reg[i] == '0)
            begin
                zero_ext = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline
    // ------------------------------------------------------------------
    logic [NST-1:0] valid_reg;
    stage_t         stage_reg  [NST-1];
    stage_t         stage_next [NST-1];
    logic           adv;

    // advance everything unless the output word is held
    assign adv       = !valid_reg[NST-1] || rsp.ready;
    assign req.ready = adv;

    always_comb
    begin
        stage_next[0]          = '0;
        stage_next[0].func     = req.func;
        stage_next[0].n        = req.flat_in;
        stage_next[0].coord    = req.coord_in;
        stage_next[0].stride   = FLAT_BITS'(1);
        stage_next[0].bad      = (req.func == FUNC_SPLIT) && zero_ext;
    end

    for (genvar g = 1; g < NST-1; g++)
    begin : g_stage
        localparam int K   = (g - 1) / SPD;
        localparam int J   = (g - 1) % SPD;
        localparam int DIM = MAX_DIMS - 1 - K;

        always_comb
        begin : stage_logic
            logic [COORD_BITS:0]   t;
            logic [COORD_BITS-1:0] c;
            logic [FLAT_BITS:0]    sum_full;
            stage_t                s;
            t        = '0;
            c        = '0;
            sum_full = '0;
            s        = stage_reg[g-1];

            // restoring division steps, most significant quotient bit first
            for (int b = 0; b < BPS; b++)
            begin
                if (J*BPS + b < FLAT_BITS)
                begin
                    t   = {s.rem, s.n[FLAT_BITS-1]};
                    s.n = {s.n[FLAT_BITS-2:0], 1'b0};
                    if (t >= {1'b0, div_ext[DIM]})
                    begin
                        s.rem  = COORD_BITS'(t - {1'b0, div_ext[DIM]});
                        s.n[0] = 1'b1;
                    end
                    else
                    begin
                        s.rem = t[COORD_BITS-1:0];
                    end
                end
            end

            // end of section: remainder is this dimension's coordinate
            if (J == SPD-1)
            begin
                if (s.func == FUNC_SPLIT)
                begin
                    s.coord[DIM] = s.rem;
                end
                s.rem = '0;
            end

            // fold: multiply coordinate and extent by the running stride
            if (J == 0 && s.func == FUNC_FOLD)
            begin
                c = used[DIM] ? s.coord[DIM] : '0;
                if (used[DIM] && s.coord[DIM] >= extent_reg[DIM])
                begin
                    s.bad = 1'b1;
                end
                s.cnz   = (c != '0);
                s.tprod = PW'(c) * PW'(s.stride);
                s.sprod = PW'(fold_ext[DIM]) * PW'(s.stride);
            end

            // fold: accumulate and track overflow
            if (J == 1 && s.func == FUNC_FOLD)
            begin
                if (s.cnz && s.big)
                begin
                    s.bad = 1'b1;
                end
                if (!s.big && s.tprod[PW-1:FLAT_BITS] != '0)
                begin
                    s.bad = 1'b1;
                end
                sum_full = {1'b0, s.sum} + {1'b0, s.tprod[FLAT_BITS-1:0]};
                if (sum_full[FLAT_BITS])
                begin
                    s.bad = 1'b1;
                end
                s.sum = sum_full[FLAT_BITS-1:0];
                if (s.sprod[PW-1:FLAT_BITS] != '0)
                begin
                    s.big = 1'b1;
                end
                s.stride = s.sprod[FLAT_BITS-1:0];
            end

            stage_next[g] = s;
        end
    end

    for (genvar g = 0; g < NST-1; g++)
    begin : g_stage_reg
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NST-2:0], req.valid};
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [FLAT_BITS-1:0]            flat_out_reg;
    logic [FLAT_BITS-1:0]            flat_out_next;
    logic [MAX_DIMS*COORD_BITS-1:0]  coord_out_reg;
    logic [MAX_DIMS*COORD_BITS-1:0]  coord_out_next;
    logic                            oor_reg;
    logic                            oor_next;

    always_comb
    begin
        if (stage_reg[NST-2].func == FUNC_SPLIT)
        begin
            flat_out_next  = '0;
            coord_out_next = stage_reg[NST-2].coord;
            // nonzero final quotient: flat index beyond the extents' product
            oor_next = stage_reg[NST-2].bad || (stage_reg[NST-2].n != '0);
        end
        else
        begin
            flat_out_next  = stage_reg[NST-2].sum;
            coord_out_next = '0;
            oor_next       = stage_reg[NST-2].bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flat_out_reg  <= flat_out_next;
            coord_out_reg <= coord_out_next;
            oor_reg       <= oor_next;
        end
    end

    assign rsp.valid        = valid_reg[NST-1];
    assign rsp.flat_out     = flat_out_reg;
    assign rsp.coord_out    = coord_out_reg;
    assign rsp.out_of_range = oor_reg;

endmodule

`default_nettype wire
